FILE: sv/matrix_multiply_mod_top_defines.svh
// Assertion macros shared by the matrix multiply RTL.
// No dependencies; include by bare file name.
`ifndef MATRIX_MULTIPLY_MOD_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_MOD_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mmm_pkg.sv
// Shared types, constants and helpers for the modular matrix multiplier.
// No dependencies.
package mmm_pkg;

	localparam int MAX_DIM     = 8;
	localparam int VALUE_WIDTH = 63;
	localparam int CELLS       = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = $clog2(CELLS);
	localparam int IDX_W       = $clog2(MAX_DIM);
	localparam int DIM_W       = 4;
	localparam int CNT_W       = ADDR_W + 1;
	localparam int STEP_W      = $clog2(VALUE_WIDTH);
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 64;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [DIM_W-1:0]       dim_t;

	typedef enum logic [1:0] {
		REG_MODULUS = 2'd0,
		REG_ROWS    = 2'd1,
		REG_INNER   = 2'd2,
		REG_COLS    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_READ,
		S_RED_GO,
		S_RED_WAIT,
		S_MUL_WAIT,
		S_ACC,
		S_EMIT
	} seq_state_t;

	typedef struct packed {
		logic   start;
		value_t x;
		value_t y;
	} mul_req_t;

	typedef struct packed {
		logic   done;
		value_t value;
	} mul_rsp_t;

	// (a + b) mod m for a, b < m
	function automatic value_t add_mod(value_t a, value_t b, value_t m);
		logic [VALUE_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[VALUE_WIDTH-1:0];
	endfunction

	// 0 counts as 1, above MAX_DIM counts as MAX_DIM
	function automatic dim_t dim_of(dim_t v);
		if (v == '0) begin
			return dim_t'(1);
		end else if (v > dim_t'(MAX_DIM)) begin
			return dim_t'(MAX_DIM);
		end
		return v;
	endfunction

endpackage

FILE: sv/matrix_multiply_mod_top.sv
// Top level of the modular matrix multiplier: config port, load, sequencer.
// Depends on mmm_pkg, mmm_ram, mmm_mulmod and matrix_multiply_mod_top_defines.svh.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+-------------------------------------
//  input     | start & !busy                    | entry_value
//  result    | result_valid (one-cycle strobe)  | product_value, out_row, out_col, last_entry
//  config    | psel & penable & pwrite (APB)    | paddr, pwdata / prdata
//
// Loading takes one item per cycle; busy stays low until the last entry of B.
// Each multiply-add reads A and B from their stores, reduces the A entry with the
// bit-serial unit, multiplies with the same unit and accumulates. One result sums
// inner multiply-adds and the whole product has rows*cols results; the serial
// multiplier sets the pace. busy stays high until the last result strobe. Reset
// clears the load position and all control state; the stores hold garbage until
// loaded. Results cannot be stalled.
module matrix_multiply_mod_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  mmm_pkg::value_t               entry_value,
	output logic                          result_valid,
	output mmm_pkg::value_t               product_value,
	output mmm_pkg::idx_t                 out_row,
	output mmm_pkg::idx_t                 out_col,
	output logic                          last_entry,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mmm_pkg::PADDR_W-1:0]   paddr,
	input  logic [mmm_pkg::PDATA_W-1:0]   pwdata,
	output logic [mmm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import mmm_pkg::*;

	`include "matrix_multiply_mod_top_defines.svh"

	// configuration
	value_t     modulus_q;
	dim_t       rows_q;
	dim_t       inner_q;
	dim_t       cols_q;
	reg_idx_t   reg_sel;
	logic       cfg_wr;

	// load and sequencing
	seq_state_t state_q, state_d;
	logic [CNT_W-1:0] load_cnt_q;
	logic       second_q;
	idx_t       i_q, j_q, k_q;
	value_t     acc_q;
	value_t     ra_q;
	value_t     prod_q;

	dim_t       nr, nk, nc;
	logic       accept;
	logic [CNT_W-1:0] load_next;
	logic [CNT_W-1:0] a_need, b_need;
	logic       last_load;
	logic       k_last, j_last, i_last;
	logic       mod_ok;

	addr_t      a_raddr, b_raddr;
	value_t     a_rd, b_rd;
	mul_req_t   mreq;
	mul_rsp_t   mrsp;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:PADDR_W-2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_sel)
			REG_MODULUS: prdata = {1'b0, modulus_q};
			REG_ROWS:    prdata = PDATA_W'(rows_q);
			REG_INNER:   prdata = PDATA_W'(inner_q);
			REG_COLS:    prdata = PDATA_W'(cols_q);
			default:     prdata = '0;
		endcase
	end

	assign nr = dim_of(rows_q);
	assign nk = dim_of(inner_q);
	assign nc = dim_of(cols_q);

	assign busy      = (state_q != S_LOAD);
	assign accept    = start && !busy;
	assign load_next = load_cnt_q + CNT_W'(1);
	assign a_need    = CNT_W'(nr) * CNT_W'(nk);
	assign b_need    = CNT_W'(nk) * CNT_W'(nc);
	assign last_load = second_q ? (load_next >= b_need) : (load_next >= a_need);

	assign k_last = ({1'b0, k_q} == nk - dim_t'(1));
	assign j_last = ({1'b0, j_q} == nc - dim_t'(1));
	assign i_last = ({1'b0, i_q} == nr - dim_t'(1));
	assign mod_ok = (modulus_q >= value_t'(2));

	// A is nr x nk, B is nk x nc, both row-major
	assign a_raddr = ADDR_W'(i_q) * ADDR_W'(nk) + ADDR_W'(k_q);
	assign b_raddr = ADDR_W'(k_q) * ADDR_W'(nc) + ADDR_W'(j_q);

	mmm_ram u_a_store (
		.clk   (clk),
		.we    (accept && !second_q),
		.waddr (load_cnt_q[ADDR_W-1:0]),
		.wdata (entry_value),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	mmm_ram u_b_store (
		.clk   (clk),
		.we    (accept && second_q),
		.waddr (load_cnt_q[ADDR_W-1:0]),
		.wdata (entry_value),
		.raddr (b_raddr),
		.rdata (b_rd)
	);

	mmm_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.modulus (modulus_q),
		.rsp     (mrsp)
	);

	// configuration registers; a dimension write restarts the load with A
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= value_t'(64'd2147483647);
			rows_q    <= dim_t'(MAX_DIM);
			inner_q   <= dim_t'(MAX_DIM);
			cols_q    <= dim_t'(MAX_DIM);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_MODULUS: modulus_q <= pwdata[VALUE_WIDTH-1:0];
				REG_ROWS:    rows_q    <= pwdata[DIM_W-1:0];
				REG_INNER:   inner_q   <= pwdata[DIM_W-1:0];
				REG_COLS:    cols_q    <= pwdata[DIM_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and multiplier requests
	always_comb begin
		state_d    = state_q;
		mreq.start = 1'b0;
		mreq.x     = value_t'(1);
		mreq.y     = a_rd;
		unique case (state_q)
			S_LOAD: begin
				if (accept && second_q && last_load) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_RED_GO;
			end
			S_RED_GO: begin
				// reduce the A entry: 1 * a mod m
				mreq.start = 1'b1;
				state_d    = S_RED_WAIT;
			end
			S_RED_WAIT: begin
				if (mrsp.done) begin
					mreq.start = 1'b1;
					mreq.x     = mrsp.value;
					mreq.y     = b_rd;
					state_d    = S_MUL_WAIT;
				end
			end
			S_MUL_WAIT: begin
				if (mrsp.done) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				state_d = k_last ? S_EMIT : S_READ;
			end
			S_EMIT: begin
				state_d = (i_last && j_last) ? S_LOAD : S_READ;
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// load position and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			second_q   <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
		end else begin
			if (cfg_wr && reg_sel != REG_MODULUS) begin
				load_cnt_q <= '0;
				second_q   <= 1'b0;
			end else if (accept) begin
				if (last_load) begin
					load_cnt_q <= '0;
					second_q   <= !second_q;
				end else begin
					load_cnt_q <= load_next;
				end
			end
			if (state_q == S_LOAD) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (state_q == S_ACC && !k_last) begin
				k_q <= k_q + idx_t'(1);
			end else if (state_q == S_EMIT) begin
				// advance row-major over C
				k_q <= '0;
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + idx_t'(1);
				end else begin
					j_q <= j_q + idx_t'(1);
				end
			end
		end
	end

	// datapath: hold reduced A, product and running sum
	always_ff @(posedge clk) begin
		if (state_q == S_RED_WAIT && mrsp.done) begin
			ra_q <= mrsp.value;
		end
		if (state_q == S_MUL_WAIT && mrsp.done) begin
			prod_q <= mrsp.value;
		end
		if (state_q == S_LOAD || state_q == S_EMIT) begin
			acc_q <= '0;
		end else if (state_q == S_ACC) begin
			acc_q <= add_mod(acc_q, prod_q, modulus_q);
		end
	end

	assign result_valid  = (state_q == S_EMIT);
	assign product_value = mod_ok ? acc_q : '0;
	assign out_row       = i_q;
	assign out_col       = j_q;
	assign last_entry    = i_last && j_last;

	`MMM_ASSERT_NOW(a_strobe_busy, clk, arst_n, result_valid, busy,
		"result strobe outside compute")
	`MMM_ASSERT_NOW(a_result_reduced, clk, arst_n, result_valid && mod_ok,
		product_value < modulus_q, "result not reduced")
	`MMM_ASSERT_NEXT(a_last_frees, clk, arst_n, result_valid && last_entry,
		!busy, "block still busy after last result")
	`MMM_ASSERT_NOW(a_acc_reduced, clk, arst_n, state_q == S_ACC && mod_ok,
		acc_q < modulus_q && ra_q < modulus_q, "accumulator not reduced")

endmodule

FILE: sv/mmm_ram.sv
// Single matrix store: one write port, one read port, registered read data.
// Depends on mmm_pkg.
module mmm_ram (
	input  logic           clk,
	input  logic           we,
	input  mmm_pkg::addr_t waddr,
	input  mmm_pkg::value_t wdata,
	input  mmm_pkg::addr_t raddr,
	output mmm_pkg::value_t rdata
);
	import mmm_pkg::*;

	value_t mem [CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/mmm_mulmod.sv
// Bit-serial modular multiplier: x * y mod m, x < m, y any value.
// Each bit of y takes a double step, then a conditional add step. Depends on mmm_pkg.
module mmm_mulmod (
	input  logic              clk,
	input  logic              arst_n,
	input  mmm_pkg::mul_req_t req,
	input  mmm_pkg::value_t   modulus,
	output mmm_pkg::mul_rsp_t rsp
);
	import mmm_pkg::*;

	logic              run_q;
	logic              phase_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	value_t            r_q;
	value_t            x_q;
	value_t            y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q   <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= STEP_W'(VALUE_WIDTH - 1);
			end else if (run_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - STEP_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			x_q <= req.x;
			y_q <= req.y;
		end else if (run_q) begin
			if (!phase_q) begin
				r_q <= add_mod(r_q, r_q, modulus);
			end else begin
				if (y_q[VALUE_WIDTH-1]) begin
					r_q <= add_mod(r_q, x_q, modulus);
				end
				y_q <= {y_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = r_q;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for matrix_multiply_mod_top: loads A and B, checks C.
// Depends on mmm_pkg and the matrix_multiply_mod_top RTL.
`timescale 1ns / 1ps

module tb;
	import mmm_pkg::*;

	typedef struct {
		value_t val;
		idx_t   row;
		idx_t   col;
		logic   last;
	} product_t;

	// Tracks the block's registers and stores and keeps the queue of expected
	// product entries.
	class product_board;
		logic [63:0] modulus;
		dim_t        rows_q, inner_q, cols_q;
		value_t      a_store [CELLS];
		value_t      b_store [CELLS];
		int          load_pos;
		bit          loading_b;
		product_t    pending_q [$];
		int          errors, matched, sets_done;

		function new();
			modulus = 64'd2147483647;
			rows_q = 4'd8;
			inner_q = 4'd8;
			cols_q = 4'd8;
			load_pos = 0;
			loading_b = 0;
			errors = 0;
			matched = 0;
			sets_done = 0;
		endfunction

		function int eff(dim_t v);
			if (v == 0) return 1;
			if (v > MAX_DIM) return MAX_DIM;
			return int'(v);
		endfunction

		function void write_reg(reg_idx_t idx, logic [63:0] val);
			case (idx)
				REG_MODULUS: modulus = {1'b0, val[62:0]};
				REG_ROWS:    rows_q = val[3:0];
				REG_INNER:   inner_q = val[3:0];
				REG_COLS:    cols_q = val[3:0];
			endcase
			if (idx != REG_MODULUS) begin
				load_pos = 0;
				loading_b = 0;
			end
		endfunction

		function void note_entry(value_t v);
			int nr, nk, nc;
			logic [63:0] x1, x2, term;
			logic [64:0] s;
			logic [127:0] p;
			logic [63:0] acc [CELLS];
			product_t e;
			nr = eff(rows_q);
			nk = eff(inner_q);
			nc = eff(cols_q);
			if (!loading_b) begin
				a_store[load_pos] = v;
				load_pos++;
				if (load_pos >= nr * nk) begin
					load_pos = 0;
					loading_b = 1;
				end
				return;
			end
			b_store[load_pos] = v;
			load_pos++;
			if (load_pos < nk * nc) return;
			load_pos = 0;
			loading_b = 0;
			sets_done++;
			for (int n = 0; n < CELLS; n++) acc[n] = '0;
			if (modulus >= 2) begin
				for (int i = 0; i < nr; i++)
					for (int k = 0; k < nk; k++) begin
						x1 = {1'b0, a_store[i*nk+k]} % modulus;
						for (int j = 0; j < nc; j++) begin
							x2 = {1'b0, b_store[k*nc+j]} % modulus;
							p = {64'b0, x1} * {64'b0, x2};
							term = 64'(p % {64'b0, modulus});
							s = {1'b0, acc[i*nc+j]} + {1'b0, term};
							if (s >= {1'b0, modulus}) s = s - {1'b0, modulus};
							acc[i*nc+j] = s[63:0];
						end
					end
			end
			for (int i = 0; i < nr; i++)
				for (int j = 0; j < nc; j++) begin
					e.val = acc[i*nc+j][62:0];
					e.row = idx_t'(i);
					e.col = idx_t'(j);
					e.last = (i == nr - 1) && (j == nc - 1);
					pending_q.push_back(e);
				end
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(value_t v, idx_t r, idx_t c, logic l);
			product_t e;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected product r%0d c%0d", r, c));
				return;
			end
			e = pending_q.pop_front();
			if (v !== e.val || r !== e.row || c !== e.col || l !== e.last)
				report($sformatf("got %0h r%0d c%0d l%0b, want %0h r%0d c%0d l%0b",
					v, r, c, l, e.val, e.row, e.col, e.last));
			else
				matched++;
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	value_t              entry_value = '0;
	logic                result_valid;
	value_t              product_value;
	idx_t                out_row, out_col;
	logic                last_entry;
	logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	product_board board = new();
	int items_sent = 0;
	bit no_gaps = 0;

	matrix_multiply_mod_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.entry_value(entry_value), .result_valid(result_valid),
		.product_value(product_value), .out_row(out_row), .out_col(out_col),
		.last_entry(last_entry), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Sample the strobe with pre-edge values; results cannot be held off.
	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_result(product_value, out_row, out_col, last_entry);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Hold start until the item is taken, then idle for a random gap.
	task send_entry(value_t v);
		int gap;
		start <= 1'b1;
		entry_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_entry(v);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and wait until every expected product is out and the block is idle.
	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_q.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the access edge.
	task apb_write(reg_idx_t idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.write_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task set_dims(logic [3:0] r, logic [3:0] k, logic [3:0] c);
		apb_write(REG_ROWS, 64'(r));
		apb_write(REG_INNER, 64'(k));
		apb_write(REG_COLS, 64'(c));
	endtask

	// Entry below the modulus mostly, with edge values and unreduced noise.
	function automatic value_t pick_entry();
		int r;
		logic [63:0] m;
		m = board.modulus;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 16 && m >= 1) return value_t'(m - 1);
		if (r < 24 || m < 2) return value_t'(rand64());
		return value_t'(rand64() % m);
	endfunction

	function automatic logic [63:0] pick_modulus();
		case ($urandom_range(0, 9))
			0: return 64'd2;
			1: return 64'd3;
			2: return 64'd2147483647;
			3: return 64'h1FFF_FFFF_FFFF_FFFF;
			4: return 64'h7FFF_FFFF_FFFF_FFFF;
			5: return 64'($urandom_range(0, 1));
			6: return 64'($urandom_range(2, 1000));
			default: return rand64();
		endcase
	endfunction

	function automatic logic [3:0] pick_dim();
		if ($urandom_range(0, 24) == 0) return 4'($urandom_range(0, 15));
		return 4'($urandom_range(1, 3));
	endfunction

	task send_set();
		int n;
		n = board.eff(board.rows_q) * board.eff(board.inner_q)
			+ board.eff(board.inner_q) * board.eff(board.cols_q);
		repeat (n) send_entry(pick_entry());
	endtask

	initial begin
		reg_idx_t ri;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all-ones modulus write (bit 63 is dropped), an entry equal to the modulus, then entries one below it.
		apb_write(REG_MODULUS, 64'hFFFF_FFFF_FFFF_FFFF);
		set_dims(4'd1, 4'd1, 4'd1);
		send_entry('1);
		send_entry(value_t'(5));
		drain();
		send_entry(value_t'(64'h7FFF_FFFF_FFFF_FFFE));
		send_entry(value_t'(64'h7FFF_FFFF_FFFF_FFFE));
		drain();
		// Modulus of one, zero rows counting as one.
		apb_write(REG_MODULUS, 64'd1);
		set_dims(4'd0, 4'd2, 4'd1);
		repeat (4) send_entry(value_t'(rand64()));
		drain();
		// Modulus of zero.
		apb_write(REG_MODULUS, 64'd0);
		set_dims(4'd1, 4'd1, 4'd1);
		send_entry('1);
		send_entry('1);
		drain();
		// Oversized column count clamps to the maximum.
		apb_write(REG_MODULUS, 64'd2);
		set_dims(4'd2, 4'd1, 4'd15);
		repeat (10) send_entry(value_t'(rand64()));
		drain();
		// Dimension write during a load restarts it; modulus write does not.
		apb_write(REG_MODULUS, 64'd7);
		set_dims(4'd1, 4'd1, 4'd1);
		send_entry(value_t'(6));
		drain();
		apb_write(REG_ROWS, 64'd2);
		send_entry(value_t'(3));
		drain();
		apb_write(REG_MODULUS, 64'd11);
		send_entry(value_t'(10));
		send_entry(value_t'(9));
		drain();

		// Largest shape once, then mostly small shapes.
		apb_write(REG_MODULUS, 64'h7FFF_FFFF_FFFF_FFFF);
		set_dims(4'd8, 4'd8, 4'd8);
		no_gaps = 1;
		repeat (128) send_entry(value_t'(rand64()));
		no_gaps = 0;
		drain();

		while (items_sent < 330) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0) apb_write(REG_MODULUS, pick_modulus());
			if ($urandom_range(0, 2) != 0) set_dims(pick_dim(), pick_dim(), pick_dim());
			if ($urandom_range(0, 7) == 0) begin
				// Broken sequence: a short load of up to three entries, then a dimension write restarts it.
				repeat ($urandom_range(1, 3)) send_entry(pick_entry());
				drain();
				ri = reg_idx_t'($urandom_range(1, 3));
				apb_write(ri, 64'($urandom_range(1, 3)));
			end
			send_set();
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d items, %0d product sets, %0d product entries checked.",
			items_sent, board.sets_done, board.matched);
		$display("Moduli from zero to 2^63-1, shapes from 1x1x1 to 8x8x8, restarts.");
		if (board.errors == 0 && board.pending_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("tb failed");
		$finish;
	end

endmodule
